/* design/gsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_pkg: glyph span rectangle generator package
// Item types, character codes, sequencer states and the 5x7 font table.
// ----------------------------------------------------------------------------
package gsr_pkg;

   // Coordinate width default and the fixed field width on the ports
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int FIELD_BITS         = 16;

   // Character codes
   localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [7:0] CHAR_FIRST    = 8'd32;
   localparam logic [7:0] CHAR_LAST     = 8'd126;
   localparam logic [7:0] CHAR_QUESTION = 8'd63;

   // Glyph geometry in font dots
   localparam int GLYPH_COLS   = 5;
   localparam int GLYPH_ROWS   = 7;
   localparam int FONT_COUNT   = 95;
   localparam logic [3:0] ADVANCE_DOTS = 4'd6;
   localparam logic [3:0] NEWLINE_DOTS = 4'd10;

   // Most rectangles delivered for one character
   localparam logic [5:0] MAX_RESULTS = 6'd34;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_ORIGIN_X    = 2'd0,
      CSR_ORIGIN_Y    = 2'd1,
      CSR_GLYPH_SCALE = 2'd2
   } csr_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ORGX,
      ST_ORGY,
      ST_NLY,
      ST_NLX,
      ST_SCAN,
      ST_PUSH,
      ST_CALC,
      ST_FLUSH,
      ST_ADV
   } state_type;

   // Input item
   typedef struct packed {
      logic [7:0] char_code;
      logic       first_char;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [FIELD_BITS-1:0] rect_left;
      logic signed [FIELD_BITS-1:0] rect_top;
      logic signed [FIELD_BITS-1:0] rect_right;
      logic signed [FIELD_BITS-1:0] rect_bottom;
      logic                         last_of_char;
   } rsp_type;

   // One glyph: five column bytes, bit 0 at the top
   typedef logic [0:GLYPH_COLS-1][7:0] glyph_type;

   // Font for codes 32..126, column 0 in the top byte
   localparam glyph_type FONT_ROM [FONT_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700,
      40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001C224100,
      40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10,
      40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E,
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
      40'h3E41415132, 40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
      40'h0304780403, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204,
      40'h4040404040, 40'h0001020400, 40'h2054545478,
      40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h081454543C,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h007F102844, 40'h00417F4000, 40'h7C04180478,
      40'h7C08040478, 40'h3844444438, 40'h7C14141408,
      40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
      40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000,
      40'h0041360800, 40'h08082A1C08
   };

endpackage

/* design/glyph_span_rect_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_span_rect_generator_top: character to filled pixel rectangles
// Scans a 5x7 font glyph for column runs and row runs over one dot and emits one
// rectangle item per run, with a shared saturating coordinate unit.
// ----------------------------------------------------------------------------
// Each accepted character item is scanned column by column and then row by
// row; req_stall stays high until the whole item is finished. The scan state
// handles in turn each run found, each single-dot row run skipped, and each
// column or row end; each rectangle then has its coordinates computed in the
// shared multiply-add-saturate unit, one after another: left, top, right,
// bottom. From the second rectangle on, the previous rectangle is first
// handed to the output register. A closing step hands over the last
// rectangle, then the cursor advances and the block returns to idle to take
// the next item. Handing a rectangle over waits while rsp_stall holds the
// output. A newline moves the cursor down one line and back to the line
// start; the first flag first moves the cursor back to the origin.
// Coordinates saturate to the signed COORD_BITS range; result fields carry
// the low 16 bits. Configuration writes are always taken (csr_ready is high)
// and are meant for idle periods only.
module glyph_span_rect_generator_top #(
   parameter int COORD_BITS = gsr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // Character items
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gsr_pkg::req_type              req_data,
   // Rectangle items
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gsr_pkg::rsp_type              rsp_data,
   // Register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [gsr_pkg::FIELD_BITS-1:0] csr_data
);

   localparam int FB = gsr_pkg::FIELD_BITS;
   localparam int WB = (COORD_BITS > FB) ? COORD_BITS : FB;
   // Sum width: widest base plus headroom for the dot offset
   localparam int SW = WB + 2;
   localparam logic signed [SW-1:0] SAT_HI = {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   // Configuration registers
   logic signed [FB-1:0] origin_x_ff;
   logic signed [FB-1:0] origin_y_ff;
   logic [3:0]           scale_ff;

   // Cursor
   logic signed [COORD_BITS-1:0] cursor_x_ff, cursor_x_in;
   logic signed [COORD_BITS-1:0] cursor_y_ff, cursor_y_in;

   // Sequencer control
   gsr_pkg::state_type state_ff, state_in;
   logic       row_phase_ff, row_phase_in;
   logic [2:0] outer_ff, outer_in;
   logic [2:0] pos_ff, pos_in;
   logic [5:0] count_ff, count_in;
   logic [1:0] calc_idx_ff, calc_idx_in;
   logic       pend_valid_ff, pend_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Item payload
   gsr_pkg::glyph_type glyph_ff, glyph_in;
   logic               newline_ff, newline_in;
   logic [2:0]         spec_k_ff [4];
   logic [2:0]         spec_k_in [4];
   gsr_pkg::rsp_type   pend_ff, pend_in;
   gsr_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // Shared unit
   logic signed [SW-1:0]         unit_base;
   logic [3:0]                   unit_k;
   logic [7:0]                   unit_prod;
   logic signed [SW-1:0]         unit_sum;
   logic signed [COORD_BITS-1:0] unit_res;
   logic signed [SW-1:0]         unit_res_ext;
   logic [FB-1:0]                unit_res16;

   // Base operands
   logic signed [SW-1:0] cur_x_ext, cur_y_ext, org_x_ext, org_y_ext;

   // Scan
   logic [6:0] line_bits;
   logic [7:0] line8;
   logic       run_found;
   logic [2:0] run_start;
   logic [2:0] run_end;
   logic       run_long;
   logic       outer_last;

   // Character lookup
   logic [7:0] mapped_code;
   logic [6:0] font_idx;

   logic out_free;

   assign req_stall = (state_ff != gsr_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cur_x_ext = {{(SW-COORD_BITS){cursor_x_ff[COORD_BITS-1]}}, cursor_x_ff};
   assign cur_y_ext = {{(SW-COORD_BITS){cursor_y_ff[COORD_BITS-1]}}, cursor_y_ff};
   assign org_x_ext = {{(SW-FB){origin_x_ff[FB-1]}}, origin_x_ff};
   assign org_y_ext = {{(SW-FB){origin_y_ff[FB-1]}}, origin_y_ff};

   // Shared multiply-add-saturate: sat(base + k*scale)
   always_comb begin
      unit_prod = 8'(unit_k) * 8'(scale_ff);
      unit_sum  = unit_base + $signed({{(SW-8){1'b0}}, unit_prod});
      if (unit_sum > SAT_HI) begin
         unit_res = SAT_HI[COORD_BITS-1:0];
      end else if (unit_sum < SAT_LO) begin
         unit_res = SAT_LO[COORD_BITS-1:0];
      end else begin
         unit_res = unit_sum[COORD_BITS-1:0];
      end
      unit_res_ext = {{(SW-COORD_BITS){unit_res[COORD_BITS-1]}}, unit_res};
      unit_res16   = unit_res_ext[FB-1:0];
   end

   // Unprintable codes draw as '?'
   always_comb begin
      if (req_data.char_code < gsr_pkg::CHAR_FIRST || req_data.char_code > gsr_pkg::CHAR_LAST) begin
         mapped_code = gsr_pkg::CHAR_QUESTION;
      end else begin
         mapped_code = req_data.char_code;
      end
      font_idx = 7'(mapped_code - gsr_pkg::CHAR_FIRST);
   end

   // Current line of dots: a column, or a row gathered across the columns
   always_comb begin
      line_bits = '0;
      if (row_phase_ff) begin
         for (int c = 0; c < gsr_pkg::GLYPH_COLS; c++) begin
            line_bits[c] = glyph_ff[c][outer_ff];
         end
      end else begin
         line_bits = glyph_ff[outer_ff][6:0];
      end
      line8 = {1'b0, line_bits};
   end

   // Next run at or after pos: first set dot, then first clear dot after it
   always_comb begin
      run_found = 1'b0;
      run_start = '0;
      run_end   = 3'(gsr_pkg::GLYPH_ROWS);
      for (int i = gsr_pkg::GLYPH_ROWS - 1; i >= 0; i--) begin
         if (line_bits[i] && 3'(i) >= pos_ff) begin
            run_found = 1'b1;
            run_start = 3'(i);
         end
      end
      for (int i = 7; i >= 0; i--) begin
         if (!line8[i] && 3'(i) > run_start) begin
            run_end = 3'(i);
         end
      end
      run_long = ({1'b0, run_end} - {1'b0, run_start}) > 4'd1;
      if (row_phase_ff) begin
         outer_last = (outer_ff == 3'(gsr_pkg::GLYPH_ROWS - 1));
      end else begin
         outer_last = (outer_ff == 3'(gsr_pkg::GLYPH_COLS - 1));
      end
   end

   // Sequencer: next state and register updates
   always_comb begin
      state_in      = state_ff;
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      row_phase_in  = row_phase_ff;
      outer_in      = outer_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      calc_idx_in   = calc_idx_ff;
      pend_valid_in = pend_valid_ff;
      glyph_in      = glyph_ff;
      newline_in    = newline_ff;
      spec_k_in     = spec_k_ff;
      pend_in       = pend_ff;
      unit_base     = cur_x_ext;
      unit_k        = '0;
      // Output register: drains when taken, loads on a push below
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         gsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               glyph_in      = gsr_pkg::FONT_ROM[font_idx];
               newline_in    = (req_data.char_code == gsr_pkg::CHAR_NEWLINE);
               row_phase_in  = 1'b0;
               outer_in      = '0;
               pos_in        = '0;
               count_in      = '0;
               pend_valid_in = 1'b0;
               if (req_data.first_char) begin
                  state_in = gsr_pkg::ST_ORGX;
               end else if (req_data.char_code == gsr_pkg::CHAR_NEWLINE) begin
                  state_in = gsr_pkg::ST_NLY;
               end else begin
                  state_in = gsr_pkg::ST_SCAN;
               end
            end
         end
         // Cursor back to the origin
         gsr_pkg::ST_ORGX: begin
            unit_base   = org_x_ext;
            cursor_x_in = unit_res;
            state_in    = gsr_pkg::ST_ORGY;
         end
         gsr_pkg::ST_ORGY: begin
            unit_base   = org_y_ext;
            cursor_y_in = unit_res;
            state_in    = newline_ff ? gsr_pkg::ST_NLY : gsr_pkg::ST_SCAN;
         end
         // Newline: down one line, back to the line start
         gsr_pkg::ST_NLY: begin
            unit_base   = cur_y_ext;
            unit_k      = gsr_pkg::NEWLINE_DOTS;
            cursor_y_in = unit_res;
            state_in    = gsr_pkg::ST_NLX;
         end
         gsr_pkg::ST_NLX: begin
            unit_base   = org_x_ext;
            cursor_x_in = unit_res;
            state_in    = gsr_pkg::ST_IDLE;
         end
         // One run or one line end per cycle
         gsr_pkg::ST_SCAN: begin
            if (!run_found) begin
               pos_in = '0;
               if (outer_last) begin
                  if (row_phase_ff) begin
                     state_in = gsr_pkg::ST_FLUSH;
                  end else begin
                     row_phase_in = 1'b1;
                     outer_in     = '0;
                  end
               end else begin
                  outer_in = outer_ff + 3'd1;
               end
            end else if (row_phase_ff && !run_long) begin
               // single-dot row run is already covered by its column
               pos_in = run_end;
            end else if (count_ff == gsr_pkg::MAX_RESULTS) begin
               state_in = gsr_pkg::ST_FLUSH;
            end else begin
               pos_in      = run_end;
               count_in    = count_ff + 6'd1;
               calc_idx_in = '0;
               if (row_phase_ff) begin
                  spec_k_in[0] = run_start;
                  spec_k_in[1] = outer_ff;
                  spec_k_in[2] = run_end;
                  spec_k_in[3] = outer_ff + 3'd1;
               end else begin
                  spec_k_in[0] = outer_ff;
                  spec_k_in[1] = run_start;
                  spec_k_in[2] = outer_ff + 3'd1;
                  spec_k_in[3] = run_end;
               end
               state_in = pend_valid_ff ? gsr_pkg::ST_PUSH : gsr_pkg::ST_CALC;
            end
         end
         // Another rectangle follows, so the held one is not the last
         gsr_pkg::ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in               = pend_ff;
               rsp_data_in.last_of_char  = 1'b0;
               pend_valid_in             = 1'b0;
               state_in                  = gsr_pkg::ST_CALC;
            end
         end
         // One coordinate per cycle: left, top, right, bottom
         gsr_pkg::ST_CALC: begin
            unit_base = calc_idx_ff[0] ? cur_y_ext : cur_x_ext;
            unit_k    = {1'b0, spec_k_ff[calc_idx_ff]};
            case (calc_idx_ff)
               2'd0:    pend_in.rect_left   = unit_res16;
               2'd1:    pend_in.rect_top    = unit_res16;
               2'd2:    pend_in.rect_right  = unit_res16;
               default: pend_in.rect_bottom = unit_res16;
            endcase
            calc_idx_in = calc_idx_ff + 2'd1;
            if (calc_idx_ff == 2'd3) begin
               pend_valid_in = 1'b1;
               state_in      = gsr_pkg::ST_SCAN;
            end
         end
         // Held rectangle is the last of the character
         gsr_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = gsr_pkg::ST_ADV;
            end else if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in              = pend_ff;
               rsp_data_in.last_of_char = 1'b1;
               pend_valid_in            = 1'b0;
               state_in                 = gsr_pkg::ST_ADV;
            end
         end
         // Advance to the next character cell
         gsr_pkg::ST_ADV: begin
            unit_base   = cur_x_ext;
            unit_k      = gsr_pkg::ADVANCE_DOTS;
            cursor_x_in = unit_res;
            state_in    = gsr_pkg::ST_IDLE;
         end
         default: begin
            state_in = gsr_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gsr_pkg::ST_IDLE;
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         row_phase_ff  <= 1'b0;
         outer_ff      <= '0;
         pos_ff        <= '0;
         count_ff      <= '0;
         calc_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_x_ff   <= cursor_x_in;
         cursor_y_ff   <= cursor_y_in;
         row_phase_ff  <= row_phase_in;
         outer_ff      <= outer_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         calc_idx_ff   <= calc_idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         scale_ff    <= 4'd1;
      end else if (csr_valid) begin
         case (csr_index)
            gsr_pkg::CSR_ORIGIN_X:    origin_x_ff <= csr_data;
            gsr_pkg::CSR_ORIGIN_Y:    origin_y_ff <= csr_data;
            gsr_pkg::CSR_GLYPH_SCALE: scale_ff    <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      newline_ff  <= newline_in;
      spec_k_ff   <= spec_k_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* test/tb_glyph_span_rect_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_span_rect_generator_top: rectangle stream check for the glyph unit
// Feeds characters, predicts each rectangle by mirroring the cursor and font scan
// (or takes it as typed in the directed table) and checks it as it leaves, with random
// request gaps and receiver stalls and register changes between phases, extreme origins included.
// ----------------------------------------------------------------------------
module tb_glyph_span_rect_generator_top;

   // Run shape
   localparam int RAND_PHASES    = 7;
   localparam int PHASE_ITEMS    = 57;
   localparam int SETTLE_CYCLES  = 40;     // longer than a blank glyph keeps the block busy
   localparam int WATCHDOG_LIMIT = 3000;

   // Coordinate range and glyph geometry
   localparam int COORD_MAX = 32767;
   localparam int COORD_MIN = -32768;
   localparam int FONT_COLS = 5;
   localparam int FONT_ROWS = 7;
   localparam int ADV_DOTS  = 6;
   localparam int NL_DOTS   = 10;

   // Index past the register list; writes there are dropped
   localparam logic [1:0]       CSR_UNUSED = 2'd3;
   localparam gsr_pkg::rsp_type RECT_NONE  = '0;

   // Font for codes 32..126: five column bytes, column 0 in the top byte,
   // bit 0 of each byte is the top dot
   localparam logic [39:0] GLYPH_FONT [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h082A1C2A08, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
   };

   // Directed stimulus: character rows and register rows; n_typed >= 0 means
   // the rectangles are written out below instead of being predicted
   typedef enum logic { ROW_CHAR, ROW_REG } row_kind_type;
   typedef struct {
      row_kind_type     kind;
      logic [7:0]       code;
      logic             first_flag;
      logic [1:0]       reg_idx;
      logic [15:0]      reg_data;
      int               n_typed;
      gsr_pkg::rsp_type r0;
      gsr_pkg::rsp_type r1;
   } dir_row_type;

   localparam int DIR_LEN = 31;
   dir_row_type dir_rows [DIR_LEN] = '{
      // straight after reset: origin 0,0, scale 1
      '{ROW_CHAR, "!", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 2,
        '{16'sd2, 16'sd0, 16'sd3, 16'sd5, 1'b0}, '{16'sd2, 16'sd6, 16'sd3, 16'sd7, 1'b1}},
      '{ROW_CHAR, " ", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 0, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, "-", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, 8'h00, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, 8'hFF, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, gsr_pkg::CHAR_FIRST - 8'd1, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1,
        RECT_NONE, RECT_NONE},
      '{ROW_CHAR, gsr_pkg::CHAR_LAST + 8'd1, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1,
        RECT_NONE, RECT_NONE},
      '{ROW_CHAR, gsr_pkg::CHAR_LAST, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1,
        RECT_NONE, RECT_NONE},
      '{ROW_CHAR, gsr_pkg::CHAR_NEWLINE, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 0,
        RECT_NONE, RECT_NONE},
      '{ROW_CHAR, "@", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, "#", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, "M", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, " ", 1'b1, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 0, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, gsr_pkg::CHAR_NEWLINE, 1'b1, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 0,
        RECT_NONE, RECT_NONE},
      '{ROW_CHAR, "W", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      // top of the range, largest dots: everything pins at the maximum
      '{ROW_REG, 8'h00, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h7FFF, -1, RECT_NONE, RECT_NONE},
      '{ROW_REG, 8'h00, 1'b0, gsr_pkg::CSR_ORIGIN_Y, 16'h7FFF, -1, RECT_NONE, RECT_NONE},
      '{ROW_REG, 8'h00, 1'b0, gsr_pkg::CSR_GLYPH_SCALE, 16'h000F, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, "!", 1'b1, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 2,
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1}},
      '{ROW_CHAR, "%", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, gsr_pkg::CHAR_NEWLINE, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 0,
        RECT_NONE, RECT_NONE},
      // bottom of the range, unit dots
      '{ROW_REG, 8'h00, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h8000, -1, RECT_NONE, RECT_NONE},
      '{ROW_REG, 8'h00, 1'b0, gsr_pkg::CSR_ORIGIN_Y, 16'h8000, -1, RECT_NONE, RECT_NONE},
      '{ROW_REG, 8'h00, 1'b0, gsr_pkg::CSR_GLYPH_SCALE, 16'h0001, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, "!", 1'b1, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 2,
        '{-16'sd32766, -16'sd32768, -16'sd32765, -16'sd32763, 1'b0},
        '{-16'sd32766, -16'sd32762, -16'sd32765, -16'sd32761, 1'b1}},
      '{ROW_CHAR, "H", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      // zero-size dots; the write past the list must leave the scale alone
      '{ROW_REG, 8'h00, 1'b0, gsr_pkg::CSR_GLYPH_SCALE, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_REG, 8'h00, 1'b0, CSR_UNUSED, 16'hFFFF, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, "!", 1'b1, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 2,
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1}},
      '{ROW_CHAR, "#", 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, -1, RECT_NONE, RECT_NONE},
      '{ROW_CHAR, gsr_pkg::CHAR_NEWLINE, 1'b0, gsr_pkg::CSR_ORIGIN_X, 16'h0000, 0,
        RECT_NONE, RECT_NONE}
   };

   // DUT signals; the inputs are known from time zero
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   gsr_pkg::req_type req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   gsr_pkg::rsp_type rsp_data;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index   = gsr_pkg::CSR_ORIGIN_X;
   logic [15:0]      csr_data    = '0;

   // Predictor state: registers and cursor
   int org_x = 0;
   int org_y = 0;
   int dot_size = 1;
   int cur_x = 0;
   int cur_y = 0;

   // Rectangles still owed by the block, oldest first
   gsr_pkg::rsp_type rect_expect [$];
   gsr_pkg::rsp_type want;

   // Run bookkeeping
   int idle_pct   = 0;
   int stall_pct  = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int checked    = 0;
   int chars_sent = 0;
   int reg_writes = 0;
   int settings   = 1;

   glyph_span_rect_generator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clamp_coord(int v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic gsr_pkg::rsp_type make_rect(int l, int t, int r, int b);
      gsr_pkg::rsp_type rect;
      rect.rect_left    = 16'(clamp_coord(l));
      rect.rect_top     = 16'(clamp_coord(t));
      rect.rect_right   = 16'(clamp_coord(r));
      rect.rect_bottom  = 16'(clamp_coord(b));
      rect.last_of_char = 1'b0;
      return rect;
   endfunction

   // Random origin: near either end of the range, anywhere, or near zero
   function automatic logic [15:0] pick_origin();
      int pick;
      pick = $urandom_range(0, 3);
      case (pick)
         0: return 16'(COORD_MAX - int'($urandom_range(0, 600)));
         1: return 16'(COORD_MIN + int'($urandom_range(0, 600)));
         2: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 200));
      endcase
   endfunction

   // Cursor update plus the column-run / row-run scan of one character
   task automatic trace_glyph(input logic [7:0] code, input logic first_flag,
                              ref gsr_pkg::rsp_type rects [$]);
      logic [7:0]  glyph_code;
      logic [39:0] g;
      logic [7:0]  cols [FONT_COLS];
      int          s, col, row, start;
      rects.delete();
      s = dot_size;
      if (first_flag) begin
         cur_x = org_x;
         cur_y = org_y;
      end
      if (code == gsr_pkg::CHAR_NEWLINE) begin
         cur_y = clamp_coord(cur_y + NL_DOTS * s);
         cur_x = org_x;
         return;
      end
      glyph_code = (code < gsr_pkg::CHAR_FIRST || code > gsr_pkg::CHAR_LAST)
                   ? gsr_pkg::CHAR_QUESTION : code;
      g = GLYPH_FONT[glyph_code - gsr_pkg::CHAR_FIRST];
      for (col = 0; col < FONT_COLS; col++) cols[col] = g[8 * (FONT_COLS - 1 - col) +: 8];
      // vertical runs, column by column
      for (col = 0; col < FONT_COLS; col++) begin
         row = 0;
         while (row < FONT_ROWS) begin
            if (cols[col][row]) begin
               start = row;
               while (row < FONT_ROWS && cols[col][row]) row++;
               rects = {rects, make_rect(cur_x + col * s, cur_y + start * s,
                                         cur_x + (col + 1) * s, cur_y + row * s)};
            end else begin
               row++;
            end
         end
      end
      // horizontal runs longer than one dot, row by row
      for (row = 0; row < FONT_ROWS; row++) begin
         col = 0;
         while (col < FONT_COLS) begin
            if (cols[col][row]) begin
               start = col;
               while (col < FONT_COLS && cols[col][row]) col++;
               if (col - start > 1)
                  rects = {rects, make_rect(cur_x + start * s, cur_y + row * s,
                                            cur_x + col * s, cur_y + (row + 1) * s)};
            end else begin
               col++;
            end
         end
      end
      if (rects.size() > 0) rects[rects.size() - 1].last_of_char = 1'b1;
      cur_x = clamp_coord(cur_x + ADV_DOTS * s);
   endtask

   // Send one character and queue what it should draw
   task automatic feed_char(input logic [7:0] code, input logic first_flag,
                            input int n_typed, input gsr_pkg::rsp_type r0,
                            input gsr_pkg::rsp_type r1);
      gsr_pkg::rsp_type rects [$];
      int               gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{char_code: code, first_char: first_flag};
      do @(posedge clock); while (req_stall);
      trace_glyph(code, first_flag, rects);
      if (n_typed >= 0) begin
         rects.delete();
         if (n_typed > 0) rects = {rects, r0};
         if (n_typed > 1) rects = {rects, r1};
      end
      rect_expect = {rect_expect, rects};
      chars_sent++;
   endtask

   // Register write; caller drops csr_valid after the last one of a group
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         gsr_pkg::CSR_ORIGIN_X:    org_x = $signed(data);
         gsr_pkg::CSR_ORIGIN_Y:    org_y = $signed(data);
         gsr_pkg::CSR_GLYPH_SCALE: dot_size = data[3:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   // Wait for every owed rectangle, then let the block finish its cursor work
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (rect_expect.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random receiver stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 17);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // Rectangle checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rect_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rectangle l=%0d t=%0d r=%0d b=%0d last=%0b",
                        rsp_data.rect_left, rsp_data.rect_top, rsp_data.rect_right,
                        rsp_data.rect_bottom, rsp_data.last_of_char);
         end else begin
            want = rect_expect.pop_front();
            checked++;
            if (rsp_data.rect_left !== want.rect_left || rsp_data.rect_top !== want.rect_top
                || rsp_data.rect_right !== want.rect_right
                || rsp_data.rect_bottom !== want.rect_bottom
                || rsp_data.last_of_char !== want.last_of_char) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rectangle %0d: expected %0d,%0d,%0d,%0d last=%0b got %0d,%0d,%0d,%0d last=%0b",
                           checked, want.rect_left, want.rect_top, want.rect_right,
                           want.rect_bottom, want.last_of_char, rsp_data.rect_left,
                           rsp_data.rect_top, rsp_data.rect_right, rsp_data.rect_bottom,
                           rsp_data.last_of_char);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles, %0d rectangles owed",
                  WATCHDOG_LIMIT, rect_expect.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      int         ph, i, k;
      bit         in_regs;
      logic [7:0] code;
      logic       first_flag;

      in_regs = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table, light idling on both sides
      idle_pct  = 20;
      stall_pct = 20;
      for (i = 0; i < DIR_LEN; i++) begin
         if (dir_rows[i].kind == ROW_REG) begin
            if (!in_regs) begin
               settle();
               settings++;
            end
            in_regs = 1'b1;
            write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
         end else begin
            if (in_regs) csr_valid <= 1'b0;
            in_regs = 1'b0;
            feed_char(dir_rows[i].code, dir_rows[i].first_flag, dir_rows[i].n_typed,
                      dir_rows[i].r0, dir_rows[i].r1);
         end
      end

      // random phases, each with its own registers; the last one runs flat out
      for (ph = 0; ph < RAND_PHASES; ph++) begin
         settle();
         if (ph == RAND_PHASES - 1) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            k = $urandom_range(0, 2);
            idle_pct  = (k == 0) ? 0 : (k == 1) ? 15 : 40;
            k = $urandom_range(0, 2);
            stall_pct = (k == 0) ? 0 : (k == 1) ? 15 : 40;
         end
         write_reg(gsr_pkg::CSR_ORIGIN_X, pick_origin());
         write_reg(gsr_pkg::CSR_ORIGIN_Y, pick_origin());
         k = $urandom_range(0, 9);
         write_reg(gsr_pkg::CSR_GLYPH_SCALE,
                   (k == 0) ? 16'd0 : (k <= 2) ? 16'($urandom_range(4, 15))
                                               : 16'($urandom_range(1, 3)));
         csr_valid <= 1'b0;
         settings++;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            k = $urandom_range(0, 99);
            if (k < 6)       code = gsr_pkg::CHAR_NEWLINE;
            else if (k < 16) code = 8'($urandom_range(0, 255));
            else             code = 8'($urandom_range(gsr_pkg::CHAR_FIRST, gsr_pkg::CHAR_LAST));
            first_flag = (i == 0) || ($urandom_range(0, 19) == 0);
            feed_char(code, first_flag, -1, RECT_NONE, RECT_NONE);
         end
      end
      settle();

      $display("covered %0d characters and %0d register writes over %0d settings",
               chars_sent, reg_writes, settings);
      $display("%0d rectangles compared, %0d mismatches, %0d left unmatched",
               checked, mismatches, rect_expect.size());
      if (mismatches == 0 && rect_expect.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
